// ===== sv/sha256_message_digest_assert.svh =====
// Assertion macros for the digest block
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// implication checked every cycle outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sha_pkg.sv =====
package sha_pkg;

    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = 1;

    // one 64-byte block for the back end
    typedef struct packed {
        logic [511:0] data;
        logic         final_blk;
    } blk_req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FOLD,
        BK_EMIT
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_GATHER,
        FR_PAD1,
        FR_PAD2
    } fr_state_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] v, input int amt);
        ror = (v >> amt) | (v << (32 - amt));
    endfunction

endpackage

// ===== sv/sha_front.sv =====
module sha_front
    import sha_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     data_byte,
    input  logic           byte_valid,
    input  logic           last,
    output logic           blk_valid,
    input  logic           blk_stall,
    output blk_req_t       blk_req
);

    fr_state_t      state_reg, state_next;
    logic [511:0]   buf_reg, buf_next;
    logic [60:0]    count_reg, count_next;
    logic [511:0]   base;
    logic [5:0]     fill;
    logic [63:0]    bits;
    logic           blk_go;

    assign fill = count_reg[5:0];
    assign bits = {count_reg, 3'b000};
    assign blk_go = blk_valid && !blk_stall;

    // byte k sits at bits [511-8k -: 8]
    always_comb
    begin
        base = buf_reg;
        for (int k = 0; k < 64; k++)
        begin
            if (6'(k) == fill)
                base[511 - 8*k -: 8] = PAD_BYTE;
            else if (6'(k) > fill)
                base[511 - 8*k -: 8] = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        count_next = count_reg;
        blk_valid  = 1'b0;
        blk_req    = '{data: buf_reg, final_blk: 1'b0};
        in_stall   = 1'b1;
        unique case (state_reg)
            FR_GATHER:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        buf_next[511 - 8*fill -: 8] = data_byte;
                        count_next = count_reg + 61'd1;
                    end
                    if (byte_valid && fill == 6'd63)
                    begin
                        blk_valid = 1'b1;
                        blk_req.data = {buf_reg[511:8], data_byte};
                        in_stall = blk_stall;
                        if (!blk_stall && last)
                            state_next = FR_PAD2;
                    end
                    else if (last)
                    begin
                        state_next = FR_PAD1;
                    end
                    if (in_stall)
                    begin
                        buf_next   = buf_reg;
                        count_next = count_reg;
                        state_next = state_reg;
                    end
                end
            end
            FR_PAD1:
            begin
                blk_valid = 1'b1;
                if (fill >= 6'd56)
                begin
                    blk_req.data = base;
                    if (blk_go)
                    begin
                        buf_next   = '0;
                        state_next = FR_PAD2;
                        // mark so PAD2 writes zeros plus length
                    end
                end
                else
                begin
                    blk_req = '{data: {base[511:64], bits}, final_blk: 1'b1};
                    if (blk_go)
                    begin
                        count_next = '0;
                        state_next = FR_GATHER;
                    end
                end
            end
            FR_PAD2:
            begin
                blk_valid = 1'b1;
                // after a full or overflowing block: zeros, or 0x80 when fill is zero
                if (fill == 6'd0)
                    blk_req = '{data: {PAD_BYTE, 440'd0, bits}, final_blk: 1'b1};
                else
                    blk_req = '{data: {448'd0, bits}, final_blk: 1'b1};
                if (blk_go)
                begin
                    count_next = '0;
                    state_next = FR_GATHER;
                end
            end
            default: state_next = FR_GATHER;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_GATHER;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== sv/sha_queue.sv =====
module sha_queue
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_stall,
    input  blk_req_t wr_req,
    output logic     rd_valid,
    input  logic     rd_stall,
    output blk_req_t rd_req
);

    blk_req_t               mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wp_reg, rp_reg;
    logic [QueuePtrW:0]     cnt_reg;
    logic                   wr_go, rd_go;

    assign wr_stall = (cnt_reg == (QueuePtrW+1)'(QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_req   = mem_reg[rp_reg];
    assign wr_go    = wr_valid && !wr_stall;
    assign rd_go    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_go)
                wp_reg <= wp_reg + 1'b1;
            if (rd_go)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueuePtrW+1)'(wr_go) - (QueuePtrW+1)'(rd_go);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
            mem_reg[wp_reg] <= wr_req;
    end

endmodule

// ===== sv/sha_back.sv =====
module sha_back
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        blk_valid,
    output logic        blk_stall,
    input  blk_req_t    blk_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    bk_state_t    state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [511:0] blk_reg;
    logic         fin_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   idx_reg;
    logic [31:0]  w_cur, a15, a2, s0, s1, big0, big1, ch, maj, t1, t2;

    always_comb
    begin
        a15  = w_reg[4'(rnd_reg - 6'd15)];
        a2   = w_reg[4'(rnd_reg - 6'd2)];
        s0   = ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3);
        s1   = ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10);
        if (rnd_reg < 6'd16)
            w_cur = blk_reg[511 - 32*rnd_reg[3:0] -: 32];
        else
            w_cur = w_reg[rnd_reg[3:0]] + s0 + w_reg[4'(rnd_reg - 6'd7)] + s1;
        big1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + ROUND_K[rnd_reg] + w_cur;
        big0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    assign out_valid   = (state_reg == BK_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign digest_last = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        blk_stall  = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                blk_stall = 1'b0;
                if (blk_valid)
                    state_next = BK_ROUND;
            end
            BK_ROUND: if (rnd_reg == 6'd63) state_next = BK_FOLD;
            BK_FOLD:  state_next = fin_reg ? BK_EMIT : BK_IDLE;
            BK_EMIT:  if (!out_stall && idx_reg == 3'd7) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            for (int k = 0; k < 8; k++)
                h_reg[k] <= INIT_HASH[k];
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (state_reg == BK_FOLD)
                for (int k = 0; k < 8; k++)
                    h_reg[k] <= h_reg[k] + v_reg[k];
            if (state_reg == BK_EMIT && !out_stall)
            begin
                idx_reg <= idx_reg + 3'd1;
                // restart the hash once the last word goes
                if (idx_reg == 3'd7)
                    for (int k = 0; k < 8; k++)
                        h_reg[k] <= INIT_HASH[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && blk_valid)
        begin
            blk_reg <= blk_req.data;
            fin_reg <= blk_req.final_blk;
            for (int k = 0; k < 8; k++)
                v_reg[k] <= h_reg[k];
        end
        else if (state_reg == BK_ROUND)
        begin
            w_reg[rnd_reg[3:0]] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

// ===== sv/sha256_message_digest.sv =====
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  data_byte, byte_valid, last
// output    out        out_valid/out_stall digest_word, word_index, digest_last
//
// A byte is taken each cycle while a block gathers; a full block goes to a
// two-block queue. The back end loads each block, runs 64 rounds one round a
// cycle, folds the result into the hash and, after a final block, emits 8 words.
// Closing takes one or two padded blocks. The input stalls when a full block meets
// a full queue, and while padded blocks go out; a stalled digest word holds
// the back end. Reset loads the initial hash values and clears the byte count.
`include "sha256_message_digest_assert.svh"

module sha256_message_digest
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    logic     f_valid, f_stall, b_valid, b_stall;
    blk_req_t f_req, b_req;

    sha_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .data_byte, .byte_valid, .last,
        .blk_valid(f_valid), .blk_stall(f_stall), .blk_req(f_req)
    );

    sha_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_req(f_req),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_req(b_req)
    );

    sha_back u_back (
        .clk, .rst_n, .blk_valid(b_valid), .blk_stall(b_stall), .blk_req(b_req),
        .out_valid, .out_stall, .digest_word, .word_index, .digest_last
    );

    `SHA_ASSERT_IMP(a_last_idx, out_valid && digest_last, word_index == 3'd7, "last flag off word 7")
    `SHA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(digest_word), "stalled word moved")
    `SHA_ASSERT_IMP(a_blk_hold, b_valid && !b_stall, !out_valid, "block taken during digest output")

endmodule

// ===== dv/tb_sha256_message_digest.sv =====
`timescale 1ns / 100ps

module tb_sha256_message_digest;
    import sha_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_item_t;

    localparam int HOLD_CYCLES = 400;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KT [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    logic [60:0]  byte_count;
    digest_item_t digest_q [$];

    int  errors;
    int  idle_cycles;
    bit  idling_on;
    bit  hold_req;
    int  hold_cnt = 0;
    int  stall_left = 0;

    sha256_message_digest u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            else
                w[r] = w[r-16] + w[r-7]
                     + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                     + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + KT[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic predict_digest(input logic [7:0] db, input logic bv, input logic fin);
        int fill;
        logic [63:0] bits;
        if (bv)
        begin
            blk[byte_count[5:0]] = db;
            byte_count = byte_count + 61'd1;
            if (byte_count[5:0] == 6'd0)
                compress_block();
        end
        if (!fin)
            return;
        fill = int'(byte_count[5:0]);
        blk[fill] = PAD_BYTE;
        for (int k = fill + 1; k < 64; k++)
            blk[k] = 8'h00;
        if (fill >= 56)
        begin
            compress_block();
            for (int k = 0; k < 64; k++)
                blk[k] = 8'h00;
        end
        bits = {byte_count, 3'b000};
        for (int k = 0; k < 8; k++)
            blk[63-k] = bits[8*k +: 8];
        compress_block();
        for (int k = 0; k < 8; k++)
            digest_q.push_back('{chain[k], 3'(k), k == 7});
        chain = IV;
        byte_count = '0;
    endtask

    // drive one request at the falling edge, hold until accepted
    task automatic send_request(input logic [7:0] db, input logic bv, input logic fin);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= db;
        byte_valid <= bv;
        last       <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(db, bv, fin);
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input bit close_empty);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom), 1'b1, !close_empty && i == len - 1);
        if (close_empty || len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        send_request(8'h00, 1'b0, 1'b1);          // empty message
        send_request(8'h5a, 1'b0, 1'b0);          // neither flag: ignored
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b0);
        send_request(8'h01, 1'b0, 1'b1);          // close with prior bytes
        for (int i = 0; i < 3; i++)
            send_request(8'($urandom), 1'b1, i == 2);
    endtask

    task automatic test_pad_boundaries();
        // lengths around the one/two padding block split and block edges
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        send_message(64, 1'b1);
    endtask

    task automatic test_backpressure();
        // hold the digest port while a two-block close fills the queue
        hold_req = 1'b1;
        send_message(5, 1'b0);
        send_message(60, 1'b0);
        send_message(3, 1'b0);
        wait (hold_cnt >= HOLD_CYCLES);
        hold_req = 1'b0;
    endtask

    task automatic test_random(input int n_items, input bit with_idle);
        int sent;
        int len;
        idling_on = with_idle;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(0, 20);
            if ($urandom_range(0, 7) == 0)
            begin
                send_request(8'($urandom), 1'b0, 1'b0);
                sent += 1;
            end
            send_message(len, $urandom_range(0, 3) == 0);
            sent += len + 1;
        end
    endtask

    task automatic drain_and_finish();
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    endtask

    // stall generator: one long counted hold-off, or random bursts
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else
        begin
            if (!hold_req)
                hold_cnt <= 0;
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // check each accepted digest word against the oldest expectation
    always @(posedge clk)
    begin
        digest_item_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                errors++;
            end
            else
            begin
                exp_item = digest_q.pop_front();
                if (digest_word !== exp_item.word)
                begin
                    $error("digest_word exp %h got %h", exp_item.word, digest_word);
                    errors++;
                end
                if (word_index !== exp_item.index)
                begin
                    $error("word_index exp %0d got %0d", exp_item.index, word_index);
                    errors++;
                end
                if (digest_last !== exp_item.is_last)
                begin
                    $error("digest_last exp %0d got %0d", exp_item.is_last, digest_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        byte_valid = 1'b0;
        last       = 1'b0;
        out_stall  = 1'b0;
        errors     = 0;
        idle_cycles = 0;
        idling_on  = 1'b0;
        hold_req   = 1'b0;
        chain      = IV;
        byte_count = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        idling_on = 1'b1;
        test_pad_boundaries();
        test_backpressure();
        test_random(60, 1'b1);
        test_random(40, 1'b0);
        drain_and_finish();
    end

endmodule
